// ----- design/bpc_pkg.sv -----
// Package for the button press classifier: payload types, codes and slot table.
package bpc_pkg;

  localparam int unsigned NumButtons = 3;
  localparam int unsigned NumSlots   = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgDataW-1:0] LongPressRst   = 16'd1000;
  localparam logic [CfgDataW-1:0] OkLongPressRst = 16'd3000;

  localparam logic [CfgIdxW-1:0] CfgLongPress   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOkLongPress = 2'd1;

  localparam int unsigned BtnLeft  = 0;
  localparam int unsigned BtnRight = 1;
  localparam int unsigned BtnOk    = 2;

  localparam logic [2:0] EvLeftShort  = 3'd0;
  localparam logic [2:0] EvLeftLong   = 3'd1;
  localparam logic [2:0] EvRightShort = 3'd2;
  localparam logic [2:0] EvRightLong  = 3'd3;
  localparam logic [2:0] EvOkShort    = 3'd4;
  localparam logic [2:0] EvOkLong     = 3'd5;
  localparam logic [2:0] EvMenu       = 3'd6;
  localparam logic [2:0] EvSettings   = 3'd7;

  // event mask slots, in delivery order
  localparam logic [2:0] SlotShortLeft  = 3'd0;
  localparam logic [2:0] SlotShortRight = 3'd1;
  localparam logic [2:0] SlotShortOk    = 3'd2;
  localparam logic [2:0] SlotMenu       = 3'd3;
  localparam logic [2:0] SlotSettings   = 3'd4;
  localparam logic [2:0] SlotLongLeft   = 3'd5;
  localparam logic [2:0] SlotLongRight  = 3'd6;
  localparam logic [2:0] SlotLongOk     = 3'd7;

  typedef logic [NumSlots-1:0] ev_mask_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [2:0]  button_levels;
  } scan_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       last_event;
  } event_t;

  typedef struct packed {
    logic       push;
    ev_mask_t   mask;
  } q_wr_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } q_stat_t;

  function automatic logic [2:0] slot_code(input logic [2:0] slot);
    logic [2:0] code;
    case (slot)
      SlotShortLeft:  code = EvLeftShort;
      SlotShortRight: code = EvRightShort;
      SlotShortOk:    code = EvOkShort;
      SlotMenu:       code = EvMenu;
      SlotSettings:   code = EvSettings;
      SlotLongLeft:   code = EvLeftLong;
      SlotLongRight:  code = EvRightLong;
      SlotLongOk:     code = EvOkLong;
      default:        code = EvLeftShort;
    endcase
    return code;
  endfunction

endpackage

// ----- design/button_press_classifier.sv -----
// Top level of the button press classifier: front, mask queue, back.
//
//  channel | dir | handshake                  | word
//  scan    | in  | scan_valid_i / scan_stall_o | scan_t (now_ms, button_levels)
//  evt     | out | evt_valid_o / evt_stall_i   | event_t (event_code, last_event)
//  cfg     | in  | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// The front classifies one scan per cycle while the mask queue is not full
// (three 32-bit hold-time compares). The back sends one event word per cycle while
// the output is not stalled; it pops the next queued mask as it sends a mask's last word.
// Reset: thresholds 1000 and 3000 ms, all buttons released, no clearing pass.
// evt_stall_i holds the output word; a 2-deep mask queue then fills and
// raises scan_stall_o. cfg_ready_o is always high.
module button_press_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          scan_valid_i,
  output logic                          scan_stall_o,
  input  bpc_pkg::scan_t                scan_i,
  output logic                          evt_valid_o,
  input  logic                          evt_stall_i,
  output bpc_pkg::event_t               evt_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data_i
);

  bpc_pkg::q_wr_t    q_wr;
  bpc_pkg::q_stat_t  q_stat;
  bpc_pkg::ev_mask_t rd_mask;
  logic              pop;

  assign cfg_ready_o = 1'b1;

  bpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .scan_valid_i (scan_valid_i),
    .scan_i       (scan_i),
    .q_stat_i     (q_stat),
    .scan_stall_o (scan_stall_o),
    .q_wr_o       (q_wr)
  );

  bpc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_wr_i    (q_wr),
    .pop_i     (pop),
    .rd_mask_o (rd_mask),
    .q_stat_o  (q_stat)
  );

  bpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_mask_i   (rd_mask),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .evt_stall_i (evt_stall_i),
    .evt_valid_o (evt_valid_o),
    .evt_o       (evt_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_wr.push && q_stat.full))
    else $error("mask pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_stat.empty))
    else $error("mask popped from empty queue");

  a_push_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr.push |-> (q_wr.mask != '0))
    else $error("empty event mask queued");

  a_evt_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_valid_i && !scan_stall_o && q_stat.empty && (q_wr.mask != '0)) |=> !q_stat.empty
      || evt_valid_o)
    else $error("scan events lost");

endmodule

// ----- design/bpc_front.sv -----
// Front end: config registers, button state, per-scan event mask.
module bpc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          scan_valid_i,
  input  bpc_pkg::scan_t                scan_i,
  input  bpc_pkg::q_stat_t              q_stat_i,
  output logic                          scan_stall_o,
  output bpc_pkg::q_wr_t                q_wr_o
);

  logic [bpc_pkg::CfgDataW-1:0] long_q, ok_long_q;
  logic [2:0] held_q, held_d;
  logic [2:0] long_sent_q, long_sent_d;
  logic [1:0] combo_sent_q, combo_sent_d;
  logic [31:0] start_q [bpc_pkg::NumButtons];
  logic [31:0] start_d [bpc_pkg::NumButtons];
  bpc_pkg::ev_mask_t mask;
  logic accept;

  assign scan_stall_o = q_stat_i.full;
  assign accept       = scan_valid_i && !q_stat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q    <= bpc_pkg::LongPressRst;
      ok_long_q <= bpc_pkg::OkLongPressRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bpc_pkg::CfgLongPress:   long_q    <= cfg_data_i;
        bpc_pkg::CfgOkLongPress: ok_long_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [31:0] dur;
    logic [31:0] thr;
    logic        down, was_held, new_press, is_long;
    held_d       = held_q;
    long_sent_d  = long_sent_q;
    combo_sent_d = combo_sent_q;
    mask         = '0;
    for (int b = 0; b < bpc_pkg::NumButtons; b++) begin
      start_d[b] = start_q[b];
      thr        = {16'd0, (b == bpc_pkg::BtnOk) ? ok_long_q : long_q};
      down       = !scan_i.button_levels[b];
      was_held   = held_q[b];
      new_press  = down && !was_held;
      dur        = scan_i.now_ms - start_q[b];
      held_d[b]  = down;
      if (new_press) begin
        long_sent_d[b] = 1'b0;
        start_d[b]     = scan_i.now_ms;
      end
      if (!down && was_held && (dur < thr)) begin
        mask[b] = 1'b1;
      end
      is_long = new_press ? (thr == 32'd0) : (dur >= thr);
      if (down && !long_sent_d[b] && is_long) begin
        mask[5 + b]    = 1'b1;
        long_sent_d[b] = 1'b1;
      end
    end
    if (!scan_i.button_levels[bpc_pkg::BtnLeft] && !held_q[bpc_pkg::BtnLeft]) begin
      combo_sent_d[0] = 1'b0;
    end
    if (!scan_i.button_levels[bpc_pkg::BtnRight] && !held_q[bpc_pkg::BtnRight]) begin
      combo_sent_d[1] = 1'b0;
    end
    if (held_d[bpc_pkg::BtnOk]) begin
      if (held_d[bpc_pkg::BtnLeft] && !combo_sent_d[0]) begin
        mask[bpc_pkg::SlotMenu] = 1'b1;
        combo_sent_d[0]         = 1'b1;
      end
      if (held_d[bpc_pkg::BtnRight] && !combo_sent_d[1]) begin
        mask[bpc_pkg::SlotSettings] = 1'b1;
        combo_sent_d[1]             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      long_sent_q  <= '0;
      combo_sent_q <= '0;
      for (int b = 0; b < bpc_pkg::NumButtons; b++) begin
        start_q[b] <= '0;
      end
    end else if (accept) begin
      held_q       <= held_d;
      long_sent_q  <= long_sent_d;
      combo_sent_q <= combo_sent_d;
      for (int b = 0; b < bpc_pkg::NumButtons; b++) begin
        start_q[b] <= start_d[b];
      end
    end
  end

  assign q_wr_o.push = accept && (mask != '0);
  assign q_wr_o.mask = mask;

endmodule

// ----- design/bpc_queue.sv -----
// Two-entry queue of event masks between front and back.
module bpc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpc_pkg::q_wr_t     q_wr_i,
  input  logic               pop_i,
  output bpc_pkg::ev_mask_t  rd_mask_o,
  output bpc_pkg::q_stat_t   q_stat_o
);

  localparam int unsigned PtrW = $clog2(bpc_pkg::QueueDepth);

  bpc_pkg::ev_mask_t mem_q [bpc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push, do_pop;

  assign do_push = q_wr_i.push && (count_q != (PtrW+1)'(bpc_pkg::QueueDepth));
  assign do_pop  = pop_i && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= q_wr_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (PtrW+1)'(1);
        2'b01:   count_q <= count_q - (PtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign rd_mask_o      = mem_q[rd_ptr_q];
  assign q_stat_o.full  = (count_q == (PtrW+1)'(bpc_pkg::QueueDepth));
  assign q_stat_o.empty = (count_q == '0);

endmodule

// ----- design/bpc_back.sv -----
// Back end: walks each event mask in order, one event word per cycle while the output is not stalled.
module bpc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpc_pkg::ev_mask_t  rd_mask_i,
  input  bpc_pkg::q_stat_t   q_stat_i,
  output logic               pop_o,
  input  logic               evt_stall_i,
  output logic               evt_valid_o,
  output bpc_pkg::event_t    evt_o
);

  bpc_pkg::ev_mask_t cur_q, cur_d, low, rem;
  logic [2:0]        slot;
  logic              out_valid_q, out_free, emit;
  bpc_pkg::event_t   out_q;

  assign low      = cur_q & (~cur_q + bpc_pkg::ev_mask_t'(1));
  assign rem      = cur_q & ~low;
  assign out_free = !out_valid_q || !evt_stall_i;
  assign emit     = out_free && (cur_q != '0);
  assign pop_o    = !q_stat_i.empty && ((cur_q == '0) || (emit && (rem == '0)));

  always_comb begin
    slot = '0;
    for (int i = bpc_pkg::NumSlots - 1; i >= 0; i--) begin
      if (cur_q[i]) slot = 3'(i);
    end
  end

  always_comb begin
    if (pop_o) begin
      cur_d = rd_mask_i;
    end else if (emit) begin
      cur_d = rem;
    end else begin
      cur_d = cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q <= cur_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.event_code <= bpc_pkg::slot_code(slot);
      out_q.last_event <= (rem == '0);
    end
  end

  assign evt_valid_o = out_valid_q;
  assign evt_o       = out_q;

endmodule
